// ----- hw/rtl/fdmc_pkg.sv -----
// ---------------------------------------------------------------------------
// fdmc_pkg
// Shared types and constants for the frame difference motion centroid unit.
// ---------------------------------------------------------------------------
`default_nettype none

package fdmc_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOTION_COUNT_MIN = 2'd3;

  // Field widths
  localparam int unsigned PIXEL_W   = 16;
  localparam int unsigned GREEN_W   = 6;
  localparam int unsigned GREEN_LSB = 5;
  localparam int unsigned THRESH_W  = 6;
  localparam int unsigned SIZE_W    = 11;
  localparam int unsigned COUNT_W   = 21;
  localparam int unsigned COORD_W   = 10;
  localparam int unsigned CFG_DATA_W = COUNT_W;

  // Register reset values
  localparam logic [THRESH_W-1:0] THRESH_RST = 6'd8;
  localparam logic [SIZE_W-1:0]   WIDTH_RST  = 11'd400;
  localparam logic [SIZE_W-1:0]   HEIGHT_RST = 11'd240;
  localparam logic [COUNT_W-1:0]  MIN_RST    = 21'd200;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_LOAD
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/frame_difference_motion_centroid_unit.sv -----
// ---------------------------------------------------------------------------
// frame_difference_motion_centroid_unit
// Counts pixels whose green field changed between two frames and reports the
// changed count, a motion flag and the centroid of the changed pixels.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in_     | input     | in_valid / in_stall  | curr_pixel, prev_pixel
//  out_    | output    | out_valid / out_stall| motion, changed_pixels,
//          |           |                      | centroid_x, centroid_y
//  cfg_    | input     | cfg_we               | cfg_index, cfg_wdata
//
// Pixels stream at one per clock while in_stall is low; in_stall is high after
// the last pixel of a frame until its result is loaded. Without motion the
// divider is skipped; with motion both centroids go one quotient bit per cycle
// through a single shared restoring divider (SUM_W is 31 at the default sizes).
// The result sits in an output register; new pixels are taken while it waits,
// but the next frame end holds until the previous result has been transferred.
// Synchronous active-low reset restores all but divider and output data regs.
`default_nettype none

module frame_difference_motion_centroid_unit #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // Input pixel pairs
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [fdmc_pkg::PIXEL_W-1:0]          in_curr_pixel,
  input  wire logic [fdmc_pkg::PIXEL_W-1:0]          in_prev_pixel,
  // Frame results
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic                                       out_motion,
  output logic [fdmc_pkg::COUNT_W-1:0]               out_changed_pixels,
  output logic [fdmc_pkg::COORD_W-1:0]               out_centroid_x,
  output logic [fdmc_pkg::COORD_W-1:0]               out_centroid_y,
  // Configuration
  input  wire logic                                  cfg_we,
  input  wire logic [fdmc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [fdmc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned RW   = $clog2(MAX_HEIGHT);
  localparam int unsigned PW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned SZ0  = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                                 $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
  localparam int unsigned SZW  = (SZ0 > fdmc_pkg::SIZE_W) ? SZ0 : fdmc_pkg::SIZE_W;
  localparam int unsigned SUM_W = ((CW > RW) ? CW : RW) + PW;
  localparam int unsigned STW  = $clog2(SUM_W);
  localparam logic [SZW-1:0] MAXW_C = SZW'(MAX_WIDTH);
  localparam logic [SZW-1:0] MAXH_C = SZW'(MAX_HEIGHT);

  // Configuration registers
  logic [fdmc_pkg::THRESH_W-1:0] thresh_r;
  logic [fdmc_pkg::SIZE_W-1:0]   width_r;
  logic [fdmc_pkg::SIZE_W-1:0]   height_r;
  logic [fdmc_pkg::COUNT_W-1:0]  min_r;

  // Frame state
  fdmc_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]                 col_r;
  logic [RW-1:0]                 row_r;
  logic [SUM_W-1:0]              sum_col_r;
  logic [SUM_W-1:0]              sum_row_r;
  logic [fdmc_pkg::COUNT_W-1:0]  count_r;

  // Divider
  logic [SUM_W-1:0]              div_r;
  logic [fdmc_pkg::COUNT_W-1:0]  rem_r;
  logic [fdmc_pkg::COORD_W-1:0]  quo_r;
  logic                          ovf_r;
  logic [STW-1:0]                step_r;
  logic                          sel_y_r;
  logic                          motion_r;
  logic [fdmc_pkg::COORD_W-1:0]  cx_r;

  // Output register
  logic                          out_valid_r;
  logic                          out_motion_r;
  logic [fdmc_pkg::COUNT_W-1:0]  out_count_r;
  logic [fdmc_pkg::COORD_W-1:0]  out_cx_r;
  logic [fdmc_pkg::COORD_W-1:0]  out_cy_r;

  // Pixel path
  logic                          in_xfer;
  logic [fdmc_pkg::GREEN_W-1:0]  cur_g, prv_g, gdiff;
  logic                          changed;
  logic [SZW-1:0]                w_eff, h_eff, col_inc, row_inc;
  logic                          row_end, frame_end;

  // Sequencer strobes
  logic                          motion_now;
  logic                          div_last;
  logic                          do_load;
  logic                          out_free;

  // Divider step
  logic [fdmc_pkg::COUNT_W:0]    rem_shift;
  logic [fdmc_pkg::COUNT_W:0]    rem_diff;
  logic                          q_bit;
  logic [fdmc_pkg::COUNT_W-1:0]  rem_step;
  logic [fdmc_pkg::COORD_W-1:0]  quo_fin;
  logic                          ovf_fin;
  logic [fdmc_pkg::COORD_W-1:0]  div_res;

  assign in_stall = (state_r != fdmc_pkg::S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Green field comparison
  assign cur_g   = in_curr_pixel[fdmc_pkg::GREEN_LSB +: fdmc_pkg::GREEN_W];
  assign prv_g   = in_prev_pixel[fdmc_pkg::GREEN_LSB +: fdmc_pkg::GREEN_W];
  assign gdiff   = (cur_g >= prv_g) ? (cur_g - prv_g) : (prv_g - cur_g);
  assign changed = gdiff > thresh_r;

  // Frame size, zero treated as one and clamped to the build maximum
  always_comb begin
    if (width_r == '0) begin
      w_eff = SZW'(1);
    end else if (SZW'(width_r) > MAXW_C) begin
      w_eff = MAXW_C;
    end else begin
      w_eff = SZW'(width_r);
    end
    if (height_r == '0) begin
      h_eff = SZW'(1);
    end else if (SZW'(height_r) > MAXH_C) begin
      h_eff = MAXH_C;
    end else begin
      h_eff = SZW'(height_r);
    end
  end

  assign col_inc   = SZW'(col_r) + SZW'(1);
  assign row_inc   = SZW'(row_r) + SZW'(1);
  assign row_end   = col_inc >= w_eff;
  assign frame_end = row_end && (row_inc >= h_eff);

  // One restoring division step: one quotient bit per cycle
  assign rem_shift = {rem_r, div_r[SUM_W-1]};
  assign rem_diff  = rem_shift - {1'b0, count_r};
  assign q_bit     = rem_shift >= {1'b0, count_r};
  assign rem_step  = q_bit ? rem_diff[fdmc_pkg::COUNT_W-1:0]
                           : rem_shift[fdmc_pkg::COUNT_W-1:0];
  assign quo_fin   = {quo_r[fdmc_pkg::COORD_W-2:0], q_bit};
  assign ovf_fin   = ovf_r || quo_r[fdmc_pkg::COORD_W-1];
  assign div_res   = ovf_fin ? '1 : quo_fin;

  assign motion_now = count_r > min_r;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    div_last  = 1'b0;
    do_load   = 1'b0;
    unique case (state_r)
      fdmc_pkg::S_IDLE: begin
        if (in_xfer && frame_end) begin
          state_nxt = fdmc_pkg::S_START;
        end
      end
      fdmc_pkg::S_START: begin
        state_nxt = motion_now ? fdmc_pkg::S_DIV : fdmc_pkg::S_LOAD;
      end
      fdmc_pkg::S_DIV: begin
        if (step_r == '0) begin
          div_last = 1'b1;
          if (sel_y_r) begin
            state_nxt = fdmc_pkg::S_LOAD;
          end
        end
      end
      fdmc_pkg::S_LOAD: begin
        if (out_free) begin
          do_load   = 1'b1;
          state_nxt = fdmc_pkg::S_IDLE;
        end
      end
      default: state_nxt = fdmc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fdmc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= fdmc_pkg::THRESH_RST;
      width_r  <= fdmc_pkg::WIDTH_RST;
      height_r <= fdmc_pkg::HEIGHT_RST;
      min_r    <= fdmc_pkg::MIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fdmc_pkg::REG_DIFF_THRESHOLD:   thresh_r <= cfg_wdata[fdmc_pkg::THRESH_W-1:0];
        fdmc_pkg::REG_FRAME_WIDTH:      width_r  <= cfg_wdata[fdmc_pkg::SIZE_W-1:0];
        fdmc_pkg::REG_FRAME_HEIGHT:     height_r <= cfg_wdata[fdmc_pkg::SIZE_W-1:0];
        fdmc_pkg::REG_MOTION_COUNT_MIN: min_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Position counters and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      sum_col_r <= '0;
      sum_row_r <= '0;
      count_r   <= '0;
    end else if (in_xfer) begin
      if (changed) begin
        sum_col_r <= sum_col_r + SUM_W'(col_r);
        sum_row_r <= sum_row_r + SUM_W'(row_r);
        if (count_r != '1) begin
          count_r <= count_r + 1'b1;
        end
      end
      if (!row_end) begin
        col_r <= col_r + 1'b1;
      end else begin
        col_r <= '0;
        row_r <= frame_end ? '0 : (row_r + 1'b1);
      end
    end else if (do_load) begin
      // The sums held still for the division; the frame is now reported.
      sum_col_r <= '0;
      sum_row_r <= '0;
      count_r   <= '0;
    end
  end

  // Divider datapath
  always_ff @(posedge clk) begin
    if (state_r == fdmc_pkg::S_START) begin
      motion_r <= motion_now;
      sel_y_r  <= 1'b0;
      div_r    <= sum_col_r;
      rem_r    <= '0;
      quo_r    <= '0;
      ovf_r    <= 1'b0;
      step_r   <= STW'(SUM_W - 1);
      cx_r     <= '0;
    end else if (state_r == fdmc_pkg::S_DIV) begin
      if (div_last) begin
        if (!sel_y_r) begin
          // X quotient done; restart the same unit on the row sum.
          cx_r    <= div_res;
          sel_y_r <= 1'b1;
          div_r   <= sum_row_r;
          rem_r   <= '0;
          quo_r   <= '0;
          ovf_r   <= 1'b0;
          step_r  <= STW'(SUM_W - 1);
        end else begin
          quo_r <= div_res;
        end
      end else begin
        div_r  <= {div_r[SUM_W-2:0], 1'b0};
        rem_r  <= rem_step;
        quo_r  <= quo_fin;
        ovf_r  <= ovf_fin;
        step_r <= step_r - 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (do_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      out_motion_r <= motion_r;
      out_count_r  <= count_r;
      out_cx_r     <= motion_r ? cx_r : '0;
      out_cy_r     <= motion_r ? quo_r : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_motion         = out_motion_r;
  assign out_changed_pixels = out_count_r;
  assign out_centroid_x     = out_cx_r;
  assign out_centroid_y     = out_cy_r;

endmodule

`default_nettype wire
